[hw/rtl/scc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_pkg
// Shared constants and types of the sphere against capsule collision unit.
// ----------------------------------------------------------------------------
package scc_pkg;

  localparam int COORD_BITS_DEF       = 32;
  localparam int NORMAL_FRAC_BITS_DEF = 14;
  localparam int T_FRAC               = 32;

  // nearest point on the segment: first end, second end or interior
  typedef enum logic [1:0] {
    SEL_A,
    SEL_B,
    SEL_T
  } sel_t;

endpackage

[hw/rtl/scc_div.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_div
// Pipelined restoring divider, one quotient bit per stage, shared divisor
// across several lanes, with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module scc_div #(
  parameter int LANES = 1,
  parameter int DW    = 8,
  parameter int QB    = 8,
  parameter int SBW   = 1
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        en,
  input  logic                        in_valid,
  input  logic [LANES-1:0][DW-1:0]    r0,
  input  logic [LANES-1:0][QB-1:0]    lo,
  input  logic [DW-1:0]               d,
  input  logic [SBW-1:0]              sb_in,
  output logic                        out_valid,
  output logic [LANES-1:0][QB-1:0]    q,
  output logic [SBW-1:0]              sb_out
);

  logic [QB-1:0]                v_r;
  logic [LANES-1:0][DW-1:0]     r_r  [QB];
  logic [LANES-1:0][QB-1:0]     q_r  [QB];
  logic [LANES-1:0][QB-1:0]     lo_r [QB];
  logic [DW-1:0]                d_r  [QB];
  logic [SBW-1:0]               sb_r [QB];

  for (genvar k = 0; k < QB; k++) begin : g_st
    logic                       vi;
    logic [LANES-1:0][DW-1:0]   ri;
    logic [LANES-1:0][QB-1:0]   qi;
    logic [LANES-1:0][QB-1:0]   li;
    logic [DW-1:0]              di;
    logic [SBW-1:0]             si;
    logic [LANES-1:0][DW:0]     tr;
    logic [LANES-1:0]           ge;
    logic [LANES-1:0][DW-1:0]   r_nxt;
    logic [LANES-1:0][QB-1:0]   q_nxt;

    if (k == 0) begin : g_first
      assign vi = in_valid;
      assign ri = r0;
      assign qi = '0;
      assign li = lo;
      assign di = d;
      assign si = sb_in;
    end else begin : g_next
      assign vi = v_r[k-1];
      assign ri = r_r[k-1];
      assign qi = q_r[k-1];
      assign li = lo_r[k-1];
      assign di = d_r[k-1];
      assign si = sb_r[k-1];
    end

    always_comb begin
      for (int l = 0; l < LANES; l++) begin
        tr[l]    = {ri[l], li[l][QB-1-k]};
        ge[l]    = tr[l] >= {1'b0, di};
        r_nxt[l] = ge[l] ? DW'(tr[l] - {1'b0, di}) : tr[l][DW-1:0];
        q_nxt[l] = {qi[l][QB-2:0], ge[l]};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        r_r[k]  <= r_nxt;
        q_r[k]  <= q_nxt;
        lo_r[k] <= li;
        d_r[k]  <= di;
        sb_r[k] <= si;
      end
    end
  end

  assign out_valid = v_r[QB-1];
  assign q         = q_r[QB-1];
  assign sb_out    = sb_r[QB-1];

endmodule

[hw/rtl/scc_sqrt.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scc_sqrt
// Pipelined integer square root, one root bit per stage, floor result,
// with a sideband word carried alongside.
// ----------------------------------------------------------------------------
module scc_sqrt #(
  parameter int XW  = 8,
  parameter int SBW = 1
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                en,
  input  logic                in_valid,
  input  logic [XW-1:0]       x,
  input  logic [SBW-1:0]      sb_in,
  output logic                out_valid,
  output logic [XW/2-1:0]     root,
  output logic [SBW-1:0]      sb_out
);

  localparam int RW = XW / 2;

  logic [RW-1:0]   v_r;
  logic [XW-1:0]   rem_r  [RW];
  logic [RW-1:0]   root_r [RW];
  logic [SBW-1:0]  sb_r   [RW];

  for (genvar k = 0; k < RW; k++) begin : g_st
    localparam int B = RW - 1 - k;
    logic            vi;
    logic [XW-1:0]   remi;
    logic [RW-1:0]   rti;
    logic [SBW-1:0]  si;
    logic [XW:0]     term;
    logic            ge;
    logic [XW-1:0]   rem_nxt;
    logic [RW-1:0]   root_nxt;

    if (k == 0) begin : g_first
      assign vi   = in_valid;
      assign remi = x;
      assign rti  = '0;
      assign si   = sb_in;
    end else begin : g_next
      assign vi   = v_r[k-1];
      assign remi = rem_r[k-1];
      assign rti  = root_r[k-1];
      assign si   = sb_r[k-1];
    end

    // (root + 2^b)^2 - root^2
    assign term     = ((XW+1)'(rti) << (B + 1)) | ((XW+1)'(1) << (2 * B));
    assign ge       = {1'b0, remi} >= term;
    assign rem_nxt  = ge ? XW'({1'b0, remi} - term) : remi;
    assign root_nxt = ge ? (rti | (RW'(1) << B)) : rti;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en) begin
        v_r[k] <= vi;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= rem_nxt;
        root_r[k] <= root_nxt;
        sb_r[k]   <= si;
      end
    end
  end

  assign out_valid = v_r[RW-1];
  assign root      = root_r[RW-1];
  assign sb_out    = sb_r[RW-1];

endmodule

[hw/rtl/sphere_capsule_collision_unit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sphere_capsule_collision_unit
// Sphere against capsule test: nearest point on the segment, distance,
// penetration depth and unit normal, fully pipelined.
// ----------------------------------------------------------------------------
// Takes one sphere/capsule word per clock and returns one result word per
// word, in order. The depth of the pipeline is set by the 32-stage segment
// parameter divider, the COORD_BITS+2 stage square root and the
// NORMAL_FRAC_BITS+1 stage normal divider. When the result side stalls, the
// whole pipeline holds and in_ready drops; no word is lost or repeated.
module sphere_capsule_collision_unit #(
  parameter int COORD_BITS       = scc_pkg::COORD_BITS_DEF,
  parameter int NORMAL_FRAC_BITS = scc_pkg::NORMAL_FRAC_BITS_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic signed [COORD_BITS-1:0]      in_sphere_x,
  input  logic signed [COORD_BITS-1:0]      in_sphere_y,
  input  logic signed [COORD_BITS-1:0]      in_sphere_z,
  input  logic        [COORD_BITS-2:0]      in_sphere_radius,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_y,
  input  logic signed [COORD_BITS-1:0]      in_seg_a_z,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_x,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_y,
  input  logic signed [COORD_BITS-1:0]      in_seg_b_z,
  input  logic        [COORD_BITS-2:0]      in_capsule_radius,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic                              out_hit,
  output logic signed [COORD_BITS-1:0]      out_depth,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_x,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_y,
  output logic signed [NORMAL_FRAC_BITS+1:0] out_normal_z
);

  localparam int CB   = COORD_BITS;
  localparam int AW   = CB + 1;
  localparam int PW   = 2 * AW;
  localparam int DW   = PW + 2;
  localparam int RW   = DW / 2;
  localparam int NF   = NORMAL_FRAC_BITS;
  localparam int QB   = NF + 1;
  localparam int NW   = NF + 2;
  localparam int NNW  = RW + QB;
  localparam int TF   = scc_pkg::T_FRAC;
  localparam int MW   = AW + TF + 1;
  localparam int DEPW = RW + 2;
  localparam int SB1W = 6 * AW + CB + 2;
  localparam int SB2W = 3 + 3 * AW + CB;
  localparam int SB3W = 3 + 2 + CB;

  localparam logic signed [MW-1:0]   RND  = {{(MW-TF){1'b0}}, 1'b1, {(TF-1){1'b0}}};
  localparam logic signed [DEPW-1:0] DMAX = {{(DEPW-CB+1){1'b0}}, {(CB-1){1'b1}}};
  localparam logic signed [DEPW-1:0] DMIN = {{(DEPW-CB+1){1'b1}}, {(CB-1){1'b0}}};
  localparam logic [QB-1:0]          ONE  = {1'b1, {NF{1'b0}}};

  logic en;
  logic out_valid_r;

  assign en        = !out_valid_r || out_ready;
  assign in_ready  = en;
  assign out_valid = out_valid_r;

  logic signed [CB-1:0] p_in [3];
  logic signed [CB-1:0] a_in [3];
  logic signed [CB-1:0] b_in [3];

  assign p_in[0] = in_sphere_x;
  assign p_in[1] = in_sphere_y;
  assign p_in[2] = in_sphere_z;
  assign a_in[0] = in_seg_a_x;
  assign a_in[1] = in_seg_a_y;
  assign a_in[2] = in_seg_a_z;
  assign b_in[0] = in_seg_b_x;
  assign b_in[1] = in_seg_b_y;
  assign b_in[2] = in_seg_b_z;

  // stage 1: segment and sphere offsets from the first end
  logic                 v1_r;
  logic signed [AW-1:0] ab1_r [3];
  logic signed [AW-1:0] ap1_r [3];
  logic [CB-1:0]        rsum1_r;

  // stage 2: products
  logic                 v2_r;
  logic signed [PW-1:0] sq2_r [3];
  logic signed [PW-1:0] pr2_r [3];
  logic signed [AW-1:0] ab2_r [3];
  logic signed [AW-1:0] ap2_r [3];
  logic [CB-1:0]        rsum2_r;

  // stage 3: dot products
  logic                 v3_r;
  logic signed [DW-1:0] den3_r;
  logic signed [DW-1:0] num3_r;
  logic signed [AW-1:0] ab3_r [3];
  logic signed [AW-1:0] ap3_r [3];
  logic [CB-1:0]        rsum3_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid && in_ready;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        ab1_r[i] <= AW'(b_in[i]) - AW'(a_in[i]);
        ap1_r[i] <= AW'(p_in[i]) - AW'(a_in[i]);
        sq2_r[i] <= ab1_r[i] * ab1_r[i];
        pr2_r[i] <= ap1_r[i] * ab1_r[i];
        ab2_r[i] <= ab1_r[i];
        ap2_r[i] <= ap1_r[i];
        ab3_r[i] <= ab2_r[i];
        ap3_r[i] <= ap2_r[i];
      end
      rsum1_r <= CB'(in_sphere_radius) + CB'(in_capsule_radius);
      rsum2_r <= rsum1_r;
      rsum3_r <= rsum2_r;
      den3_r  <= DW'(sq2_r[0]) + DW'(sq2_r[1]) + DW'(sq2_r[2]);
      num3_r  <= DW'(pr2_r[0]) + DW'(pr2_r[1]) + DW'(pr2_r[2]);
    end
  end

  scc_pkg::sel_t sel3;

  always_comb begin
    priority if (den3_r == '0 || num3_r <= 0) begin
      sel3 = scc_pkg::SEL_A;
    end else if (num3_r >= den3_r) begin
      sel3 = scc_pkg::SEL_B;
    end else begin
      sel3 = scc_pkg::SEL_T;
    end
  end

  // segment parameter t = num / den with TF fraction bits
  logic [SB1W-1:0] sb1_in;
  logic [SB1W-1:0] sb4;
  logic            v4;
  logic [TF-1:0]   tq;

  assign sb1_in = {sel3, rsum3_r, ap3_r[2], ap3_r[1], ap3_r[0], ab3_r[2], ab3_r[1], ab3_r[0]};

  scc_div #(
    .LANES (1),
    .DW    (DW),
    .QB    (TF),
    .SBW   (SB1W)
  ) u_tdiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v3_r),
    .r0        (num3_r),
    .lo        ('0),
    .d         (den3_r),
    .sb_in     (sb1_in),
    .out_valid (v4),
    .q         (tq),
    .sb_out    (sb4)
  );

  logic signed [AW-1:0] ab4 [3];
  logic signed [AW-1:0] ap4 [3];
  logic [CB-1:0]        rsum4;
  scc_pkg::sel_t        sel4;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ab4[i] = signed'(sb4[i*AW +: AW]);
      ap4[i] = signed'(sb4[(3+i)*AW +: AW]);
    end
    rsum4 = sb4[6*AW +: CB];
    sel4  = scc_pkg::sel_t'(sb4[6*AW+CB +: 2]);
  end

  // stage 5: segment times t
  logic                 v5_r;
  logic signed [MW-1:0] mt5_r [3];
  logic signed [AW-1:0] ab5_r [3];
  logic signed [AW-1:0] ap5_r [3];
  logic [CB-1:0]        rsum5_r;
  scc_pkg::sel_t        sel5_r;

  // stage 6: rounded offset of the nearest point
  logic                 v6_r;
  logic signed [AW-1:0] off6_r [3];
  logic signed [AW-1:0] ab6_r [3];
  logic signed [AW-1:0] ap6_r [3];
  logic [CB-1:0]        rsum6_r;
  scc_pkg::sel_t        sel6_r;

  // stage 7: sphere centre minus nearest point
  logic                 v7_r;
  logic signed [AW-1:0] d7_r [3];
  logic [CB-1:0]        rsum7_r;

  // stage 8: squares and magnitudes
  logic                 v8_r;
  logic signed [PW-1:0] dd8_r [3];
  logic [AW-1:0]        mag8_r [3];
  logic [2:0]           sgn8_r;
  logic [CB-1:0]        rsum8_r;

  // stage 9: squared distance
  logic                 v9_r;
  logic [DW-1:0]        ss9_r;
  logic [AW-1:0]        mag9_r [3];
  logic [2:0]           sgn9_r;
  logic [CB-1:0]        rsum9_r;

  logic signed [MW-1:0] rnd6 [3];
  logic signed [AW-1:0] sub7 [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd6[i] = mt5_r[i] + RND;
    end
  end

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      unique case (sel6_r)
        scc_pkg::SEL_A: sub7[i] = '0;
        scc_pkg::SEL_B: sub7[i] = ab6_r[i];
        scc_pkg::SEL_T: sub7[i] = off6_r[i];
        default:        sub7[i] = '0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
      v9_r <= 1'b0;
    end else if (en) begin
      v5_r <= v4;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
      v9_r <= v8_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        mt5_r[i]  <= ab4[i] * $signed({1'b0, tq});
        ab5_r[i]  <= ab4[i];
        ap5_r[i]  <= ap4[i];
        off6_r[i] <= signed'(rnd6[i][TF +: AW]);
        ab6_r[i]  <= ab5_r[i];
        ap6_r[i]  <= ap5_r[i];
        d7_r[i]   <= ap6_r[i] - sub7[i];
        dd8_r[i]  <= d7_r[i] * d7_r[i];
        mag8_r[i] <= d7_r[i][AW-1] ? AW'(-d7_r[i]) : AW'(d7_r[i]);
        sgn8_r[i] <= d7_r[i][AW-1];
        mag9_r[i] <= mag8_r[i];
      end
      sel5_r  <= sel4;
      sel6_r  <= sel5_r;
      rsum5_r <= rsum4;
      rsum6_r <= rsum5_r;
      rsum7_r <= rsum6_r;
      rsum8_r <= rsum7_r;
      rsum9_r <= rsum8_r;
      sgn9_r  <= sgn8_r;
      ss9_r   <= DW'($unsigned(dd8_r[0])) + DW'($unsigned(dd8_r[1]))
               + DW'($unsigned(dd8_r[2]));
    end
  end

  // distance
  logic [SB2W-1:0] sb2_in;
  logic [SB2W-1:0] sbs;
  logic            vs;
  logic [RW-1:0]   sep;

  assign sb2_in = {sgn9_r, mag9_r[2], mag9_r[1], mag9_r[0], rsum9_r};

  scc_sqrt #(
    .XW  (DW),
    .SBW (SB2W)
  ) u_sqrt (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v9_r),
    .x         (ss9_r),
    .sb_in     (sb2_in),
    .out_valid (vs),
    .root      (sep),
    .sb_out    (sbs)
  );

  logic [CB-1:0]         rsums;
  logic [AW-1:0]         mags [3];
  logic [2:0]            sgns;
  logic signed [DEPW-1:0] dep_nxt;
  logic                  hit_nxt;
  logic signed [CB-1:0]  sat_nxt;
  logic [NNW-1:0]        n_nxt [3];

  always_comb begin
    rsums = sbs[CB-1:0];
    for (int i = 0; i < 3; i++) begin
      mags[i]  = sbs[CB+i*AW +: AW];
      n_nxt[i] = (NNW'(mags[i]) << NF) + NNW'(sep >> 1);
    end
    sgns    = sbs[CB+3*AW +: 3];
    dep_nxt = $signed({{(DEPW-CB){1'b0}}, rsums}) - $signed({2'b00, sep});
    hit_nxt = dep_nxt > 0;
    priority if (dep_nxt > DMAX) begin
      sat_nxt = DMAX[CB-1:0];
    end else if (dep_nxt < DMIN) begin
      sat_nxt = DMIN[CB-1:0];
    end else begin
      sat_nxt = dep_nxt[CB-1:0];
    end
  end

  // stage 10: depth and normal numerators
  logic                 v10_r;
  logic [NNW-1:0]       n10_r [3];
  logic [RW-1:0]        dist10_r;
  logic                 hit10_r;
  logic                 nz10_r;
  logic signed [CB-1:0] dep10_r;
  logic [2:0]           sgn10_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v10_r <= 1'b0;
    end else if (en) begin
      v10_r <= vs;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        n10_r[i] <= n_nxt[i];
      end
      dist10_r <= sep;
      hit10_r  <= hit_nxt;
      nz10_r   <= hit_nxt && (sep != '0);
      dep10_r  <= sat_nxt;
      sgn10_r  <= sgns;
    end
  end

  // normal components |d| / distance, rounded
  logic [2:0][RW-1:0] nr0;
  logic [2:0][QB-1:0] nlo;
  logic [2:0][QB-1:0] qn;
  logic [SB3W-1:0]    sb3_in;
  logic [SB3W-1:0]    sbf;
  logic               vf;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      nr0[i] = n10_r[i][QB +: RW];
      nlo[i] = n10_r[i][QB-1:0];
    end
  end

  assign sb3_in = {sgn10_r, nz10_r, hit10_r, dep10_r};

  scc_div #(
    .LANES (3),
    .DW    (RW),
    .QB    (QB),
    .SBW   (SB3W)
  ) u_ndiv (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v10_r),
    .r0        (nr0),
    .lo        (nlo),
    .d         (dist10_r),
    .sb_in     (sb3_in),
    .out_valid (vf),
    .q         (qn),
    .sb_out    (sbf)
  );

  logic              hitf;
  logic              nzf;
  logic [2:0]        sgnf;
  logic [QB-1:0]     mn [3];
  logic signed [NW-1:0] nv_nxt [3];

  always_comb begin
    hitf = sbf[CB];
    nzf  = sbf[CB+1];
    sgnf = sbf[CB+2 +: 3];
    for (int i = 0; i < 3; i++) begin
      mn[i]     = (qn[i] > ONE) ? ONE : qn[i];
      nv_nxt[i] = nzf ? (sgnf[i] ? -signed'(NW'(mn[i])) : signed'(NW'(mn[i]))) : '0;
    end
  end

  // output word register
  logic                 out_hit_r;
  logic signed [CB-1:0] out_depth_r;
  logic signed [NW-1:0] out_nx_r;
  logic signed [NW-1:0] out_ny_r;
  logic signed [NW-1:0] out_nz_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= vf;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit_r   <= hitf;
      out_depth_r <= signed'(sbf[CB-1:0]);
      out_nx_r    <= nv_nxt[0];
      out_ny_r    <= nv_nxt[1];
      out_nz_r    <= nv_nxt[2];
    end
  end

  assign out_hit      = out_hit_r;
  assign out_depth    = out_depth_r;
  assign out_normal_x = out_nx_r;
  assign out_normal_y = out_ny_r;
  assign out_normal_z = out_nz_r;

endmodule

[test/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the sphere against capsule collision unit: random
// and directed sphere/capsule words go in with random gaps, results are taken
// with random stalls and compared in order against a bit-exact predictor.
// ----------------------------------------------------------------------------

typedef struct {
  logic signed [31:0] p[3];
  logic signed [31:0] a[3];
  logic signed [31:0] b[3];
  logic        [30:0] rs;
  logic        [30:0] rc;
} pair_t;

typedef struct {
  logic               hit;
  logic signed [31:0] depth;
  logic signed [15:0] n[3];
} contact_t;

class contact_scoreboard;
  localparam logic signed [127:0] NORM_ONE = 128'sd16384;
  contact_t pending[$];
  int       errors;

  function contact_t predict_contact(pair_t w);
    logic signed [127:0] ab[3], ap[3], c[3], dv[3];
    logic signed [127:0] den, num, ss, t, sep, cand, depth, rsv, rcv, m, mg;
    contact_t r;
    den = 0;
    num = 0;
    ss = 0;
    for (int i = 0; i < 3; i++) begin
      ab[i] = w.b[i] - w.a[i];
      ap[i] = w.p[i] - w.a[i];
      den += ab[i] * ab[i];
      num += ap[i] * ab[i];
    end
    if (den == 0 || num <= 0) begin
      for (int i = 0; i < 3; i++) c[i] = w.a[i];
    end else if (num >= den) begin
      for (int i = 0; i < 3; i++) c[i] = w.b[i];
    end else begin
      t = (num <<< 32) / den;
      for (int i = 0; i < 3; i++)
        c[i] = w.a[i] + ((ab[i] * t + (128'sd1 <<< 31)) >>> 32);
    end
    for (int i = 0; i < 3; i++) begin
      dv[i] = w.p[i] - c[i];
      ss += dv[i] * dv[i];
    end
    sep = 0;
    for (int k = 40; k >= 0; k--) begin
      cand = sep | (128'sd1 <<< k);
      if (cand * cand <= ss) sep = cand;
    end
    rsv = w.rs;
    rcv = w.rc;
    depth = rsv + rcv - sep;
    r.hit = depth > 0;
    if (depth > 128'sd2147483647) depth = 128'sd2147483647;
    if (depth < -128'sd2147483648) depth = -128'sd2147483648;
    r.depth = depth[31:0];
    for (int i = 0; i < 3; i++) begin
      m = 0;
      if (r.hit && sep != 0) begin
        mg = dv[i] < 0 ? -dv[i] : dv[i];
        m = (mg * NORM_ONE + (sep >>> 1)) / sep;
        if (m > NORM_ONE) m = NORM_ONE;
        if (dv[i] < 0) m = -m;
      end
      r.n[i] = m[15:0];
    end
    return r;
  endfunction

  function void note_pair(pair_t w);
    pending.push_back(predict_contact(w));
  endfunction

  function void check_contact(contact_t got);
    contact_t exp_c;
    bit bad;
    if (pending.size() == 0) begin
      errors++;
      if (errors <= 10) $display("unexpected result word hit=%0b depth=%0d", got.hit, got.depth);
      return;
    end
    exp_c = pending.pop_front();
    bad = got.hit !== exp_c.hit || got.depth !== exp_c.depth;
    for (int i = 0; i < 3; i++) if (got.n[i] !== exp_c.n[i]) bad = 1;
    if (bad) begin
      errors++;
      if (errors <= 10)
        $display({"result word wrong: exp hit=%0b depth=%0d n=%0d,%0d,%0d",
                  " got hit=%0b depth=%0d n=%0d,%0d,%0d"},
                 exp_c.hit, exp_c.depth, exp_c.n[0], exp_c.n[1], exp_c.n[2],
                 got.hit, got.depth, got.n[0], got.n[1], got.n[2]);
    end
  endfunction
endclass

module tb_top;
  localparam int RANDOM_ITEMS = 1200;
  localparam int DRAIN_CYCLES = 150;
  localparam int CYCLE_LIMIT  = 400000;

  logic clk, rst_n;
  logic in_valid, in_ready, out_valid, out_ready;
  logic signed [31:0] in_sphere_x, in_sphere_y, in_sphere_z;
  logic signed [31:0] in_seg_a_x, in_seg_a_y, in_seg_a_z;
  logic signed [31:0] in_seg_b_x, in_seg_b_y, in_seg_b_z;
  logic [30:0] in_sphere_radius, in_capsule_radius;
  logic out_hit;
  logic signed [31:0] out_depth;
  logic signed [15:0] out_normal_x, out_normal_y, out_normal_z;

  contact_scoreboard sb;
  bit  stim_done;
  int  cycles;
  bit  burst;

  sphere_capsule_collision_unit uut (
    .clk, .rst_n, .in_valid, .in_ready,
    .in_sphere_x, .in_sphere_y, .in_sphere_z, .in_sphere_radius,
    .in_seg_a_x, .in_seg_a_y, .in_seg_a_z,
    .in_seg_b_x, .in_seg_b_y, .in_seg_b_z, .in_capsule_radius,
    .out_valid, .out_ready, .out_hit, .out_depth,
    .out_normal_x, .out_normal_y, .out_normal_z
  );

  initial begin
    clk = 0;
    forever #1 clk = ~clk;
  end

  function automatic int draw_wait();
    if (burst) return 0;
    return $urandom_range(0, 15);
  endfunction

  function automatic logic signed [31:0] coord(int span);
    logic signed [31:0] v;
    v = $urandom;
    if (span < 32) v = $signed(v) >>> (32 - span);
    return v;
  endfunction

  task automatic send_pair(pair_t w);
    int gap;
    gap = draw_wait();
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1;
    {in_sphere_x, in_sphere_y, in_sphere_z} = {w.p[0], w.p[1], w.p[2]};
    {in_seg_a_x, in_seg_a_y, in_seg_a_z} = {w.a[0], w.a[1], w.a[2]};
    {in_seg_b_x, in_seg_b_y, in_seg_b_z} = {w.b[0], w.b[1], w.b[2]};
    in_sphere_radius = w.rs;
    in_capsule_radius = w.rc;
    do @(posedge clk); while (!in_ready);
    sb.note_pair(w);
    @(negedge clk);
  endtask

  function automatic pair_t flat_pair(logic signed [31:0] p, logic signed [31:0] a,
                                      logic signed [31:0] b, logic [30:0] rs,
                                      logic [30:0] rc);
    pair_t w;
    for (int i = 0; i < 3; i++) begin
      w.p[i] = p;
      w.a[i] = a;
      w.b[i] = b;
    end
    w.rs = rs;
    w.rc = rc;
    return w;
  endfunction

  function automatic pair_t random_pair();
    pair_t w;
    int span;
    span = ($urandom_range(0, 3) == 0) ? 32 : $urandom_range(12, 24);
    for (int i = 0; i < 3; i++) begin
      w.p[i] = coord(span);
      w.a[i] = coord(span);
      w.b[i] = ($urandom_range(0, 9) == 0) ? w.a[i] : coord(span);
    end
    if ($urandom_range(0, 7) == 0) for (int i = 0; i < 3; i++) w.p[i] = w.a[i];
    if (span == 32) begin
      w.rs = 31'($urandom);
      w.rc = 31'($urandom);
    end else begin
      w.rs = 31'($urandom_range(0, 1 << span));
      w.rc = 31'($urandom_range(0, 1 << span));
    end
    return w;
  endfunction

  initial begin
    pair_t w;
    sb = new();
    rst_n = 0;
    in_valid = 0;
    out_ready = 0;
    burst = 0;
    stim_done = 0;
    {in_sphere_x, in_sphere_y, in_sphere_z} = '0;
    {in_seg_a_x, in_seg_a_y, in_seg_a_z} = '0;
    {in_seg_b_x, in_seg_b_y, in_seg_b_z} = '0;
    in_sphere_radius = '0;
    in_capsule_radius = '0;
    repeat (9) @(negedge clk);
    rst_n = 1;
    // directed words
    send_pair(flat_pair(32'sh7fffffff, 32'sh80000000, 32'sh80000000, '1, '1));
    send_pair(flat_pair(32'sh80000000, 32'sh7fffffff, 32'sh7fffffff, 0, 0));
    send_pair(flat_pair(32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 0, 0));
    send_pair(flat_pair(0, 0, 0, '1, '1));
    send_pair(flat_pair(32'sh00010000, 0, 0, 31'h20000, 0));
    send_pair(flat_pair(32'sh00010000, 0, 0, 31'h08000, 31'h08000));
    send_pair(flat_pair(32'sh00010000, 0, 0, 31'h08000, 31'h08001));
    send_pair(flat_pair(-32'sh00010000, 0, 32'sh00040000, 31'h30000, 0));
    send_pair(flat_pair(32'sh00050000, 0, 32'sh00040000, 31'h30000, 0));
    send_pair(flat_pair(32'sh00020000, 0, 32'sh00040000, 31'h10000, 31'h1));
    send_pair(flat_pair(32'sh80000000, 32'sh80000000, 32'sh80000000, 31'h1, 0));
    w = flat_pair(0, 0, 0, 31'h30000, 31'h1);
    w.b[0] = 32'sh00100000;
    w.p[0] = 32'sh00080000;
    w.p[1] = 32'sh00010000;
    send_pair(w);
    w.p[1] = -32'sh00010000;
    w.p[2] = 32'sh00001000;
    send_pair(w);
    w = flat_pair(0, 32'sh7fffffff, 32'sh80000000, '1, '1);
    w.p[1] = 32'sh00000001;
    send_pair(w);
    w = flat_pair(32'sh00000003, 0, 0, 31'h7, 0);
    w.b[2] = 32'sh00000001;
    send_pair(w);
    send_pair(flat_pair(32'sh00000001, 0, 0, 31'h1, 31'h1));
    for (int k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 150 == 0) burst = ($urandom_range(0, 2) == 0);
      send_pair(random_pair());
    end
    in_valid = 0;
    stim_done = 1;
  end

  initial begin
    contact_t got;
    int stall;
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      stall = draw_wait();
      if (stall > 0) begin
        out_ready = 0;
        repeat (stall) @(negedge clk);
      end
      out_ready = 1;
      do @(posedge clk); while (!out_valid);
      got.hit = out_hit;
      got.depth = out_depth;
      got.n[0] = out_normal_x;
      got.n[1] = out_normal_y;
      got.n[2] = out_normal_z;
      sb.check_contact(got);
    end
  end

  initial begin
    wait (stim_done);
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("sphere_capsule_collision_unit: match");
    end else begin
      $display("sphere_capsule_collision_unit: mismatch");
    end
    $finish;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("sphere_capsule_collision_unit: mismatch");
      $finish;
    end
  end

  initial cycles = 0;
endmodule

[files.f]
hw/rtl/scc_pkg.sv
hw/rtl/scc_div.sv
hw/rtl/scc_sqrt.sv
hw/rtl/sphere_capsule_collision_unit.sv
test/tb_top.sv
